// ===== design/tsa_pkg.sv =====
package tsa_pkg;

  // Field and datapath widths
  localparam int SUM_W           = 48;
  localparam int OUT_W           = 31;
  localparam int FUNC_W          = 3;
  localparam int MODE_W          = 2;
  localparam int TIER_W          = 2;
  localparam int FLAG_W          = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int NUM_TIERS       = 4;
  localparam int STEP_W          = $clog2(SUM_W);

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 31;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE       = 3'd0,
    FN_CLOSE_MINUTE = 3'd1,
    FN_CLOSE_FIVE   = 3'd2,
    FN_CLOSE_HOUR   = 3'd3,
    FN_CLOSE_DAY    = 3'd4
  } func_e;

  typedef enum logic [TIER_W-1:0] {
    TIER_MINUTE = 2'd0,
    TIER_FIVE   = 2'd1,
    TIER_HOUR   = 2'd2,
    TIER_DAY    = 2'd3
  } tier_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ZERO   = 2'd1,
    MODE_SPAN   = 2'd2
  } mode_e;

  typedef enum logic [FLAG_W-1:0] {
    FLAG_NORMAL = 2'd0,
    FLAG_OOR    = 2'd1,
    FLAG_ZERO   = 2'd2,
    FLAG_SPAN   = 2'd3
  } flag_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_FIN
  } state_e;

  // Status from the serial divider to the sequencer
  typedef struct packed {
    logic done;
    logic out_of_range;
  } div_status_t;

endpackage

// ===== design/tsa_serial_div.sv =====
module tsa_serial_div #(
  parameter int COUNT_BITS = tsa_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsa_pkg::SUM_W-1:0]   dividend_i,
  input  logic [COUNT_BITS-1:0]       divisor_i,
  input  logic [tsa_pkg::OUT_W-1:0]   upper_i,
  input  logic [tsa_pkg::OUT_W-1:0]   lower_i,
  output logic [tsa_pkg::SUM_W-1:0]   quotient_o,
  output tsa_pkg::div_status_t        status_o
);
  import tsa_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [SUM_W-1:0]      up_sh_q, up_sh_d;
  logic [SUM_W-1:0]      lo_sh_q, lo_sh_d;
  logic                  up_dec_q, up_dec_d;
  logic                  up_gt_q, up_gt_d;
  logic                  lo_dec_q, lo_dec_d;
  logic                  lo_lt_q, lo_lt_d;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS+1:0] diff;
  logic                  qbit;
  logic                  last;

  // One restoring step: bring down the next dividend bit, try the subtract
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign qbit  = ~diff[COUNT_BITS+1];
  assign last  = (step_q == STEP_W'(SUM_W - 1));

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    step_d   = step_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    up_sh_d  = up_sh_q;
    lo_sh_d  = lo_sh_q;
    up_dec_d = up_dec_q;
    up_gt_d  = up_gt_q;
    lo_dec_d = lo_dec_q;
    lo_lt_d  = lo_lt_q;
    if (start_i) begin
      busy_d   = 1'b1;
      step_d   = '0;
      quo_d    = dividend_i;
      rem_d    = '0;
      dvs_d    = divisor_i;
      up_sh_d  = SUM_W'(upper_i);
      lo_sh_d  = SUM_W'(lower_i);
      up_dec_d = 1'b0;
      up_gt_d  = 1'b0;
      lo_dec_d = 1'b0;
      lo_lt_d  = 1'b0;
    end else if (busy_q) begin
      // Shift the quotient bit in; keep the partial remainder
      quo_d  = {quo_q[SUM_W-2:0], qbit};
      rem_d  = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      step_d = step_q + STEP_W'(1);
      // Compare quotient against both limits, most significant bit first
      if (!up_dec_q && (qbit != up_sh_q[SUM_W-1])) begin
        up_dec_d = 1'b1;
        up_gt_d  = qbit;
      end
      if (!lo_dec_q && (qbit != lo_sh_q[SUM_W-1])) begin
        lo_dec_d = 1'b1;
        lo_lt_d  = ~qbit;
      end
      up_sh_d = {up_sh_q[SUM_W-2:0], 1'b0};
      lo_sh_d = {lo_sh_q[SUM_W-2:0], 1'b0};
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    up_sh_q  <= up_sh_d;
    lo_sh_q  <= lo_sh_d;
    up_dec_q <= up_dec_d;
    up_gt_q  <= up_gt_d;
    lo_dec_q <= lo_dec_d;
    lo_lt_q  <= lo_lt_d;
  end

  // Exact average above upper when quotient is larger, or equal with a remainder; below lower when quotient is smaller
  assign quotient_o              = quo_q;
  assign status_o.done           = done_q;
  assign status_o.out_of_range   = up_gt_q | (~up_dec_q & (rem_q != '0)) |
                                   (lo_dec_q & lo_lt_q);

endmodule

// ===== design/tiered_sample_averager.sv =====
// Sample item: bit-serial sum update and min/max compare, then ready again.
// Close item: the result is registered once the radix-2 divider is done and the output is free
//   (one quotient bit per cycle over the 48-bit sum); a minute or hour close then adds the
//   average into the next tier. An empty close clears its tier and gives no result.
// One item in work at a time: a new item is taken only once the last one is finished.
// Reset (async, active low) clears all tiers, mode and output valid; limits return to defaults.
module tiered_sample_averager #(
  parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = tsa_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tsa_pkg::OUT_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tsa_pkg::FUNC_W-1:0]      func_i,
  input  logic [tsa_pkg::OUT_W-1:0]       sample_value_i,
  input  logic [tsa_pkg::MODE_W-1:0]      run_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tsa_pkg::TIER_W-1:0]      tier_o,
  output logic [tsa_pkg::OUT_W-1:0]       average_o,
  output logic [tsa_pkg::SUM_W-1:0]       total_o,
  output logic [tsa_pkg::OUT_W-1:0]       minimum_o,
  output logic [tsa_pkg::OUT_W-1:0]       maximum_o,
  output logic [tsa_pkg::FLAG_W-1:0]      quality_flag_o
);
  import tsa_pkg::*;

  // Configuration registers
  logic [OUT_W-1:0] upper_q;
  logic [OUT_W-1:0] lower_q;

  // Tier statistics
  logic [SUM_W-1:0]       sums_q [NUM_TIERS];
  logic [SUM_W-1:0]       sums_d [NUM_TIERS];
  logic [COUNT_BITS-1:0]  cnt_q  [NUM_TIERS];
  logic [COUNT_BITS-1:0]  cnt_d  [NUM_TIERS];
  logic [SAMPLE_BITS-1:0] min_q  [NUM_TIERS];
  logic [SAMPLE_BITS-1:0] min_d  [NUM_TIERS];
  logic [SAMPLE_BITS-1:0] max_q  [NUM_TIERS];
  logic [SAMPLE_BITS-1:0] max_d  [NUM_TIERS];
  logic [MODE_W-1:0]      mode_q, mode_d;

  // Serial add and compare datapath
  logic [SUM_W-1:0]       add_sh_q, add_sh_d;
  logic [SAMPLE_BITS-1:0] v_q, v_d;
  logic [NUM_TIERS-1:0]   mask_q, mask_d;
  logic [NUM_TIERS-1:0]   carry_q, carry_d;
  logic [NUM_TIERS-1:0]   lt_q, lt_d;
  logic [NUM_TIERS-1:0]   gt_q, gt_d;
  logic                   cmp_en_q, cmp_en_d;
  logic [STEP_W-1:0]      step_q, step_d;

  // Close bookkeeping
  logic [TIER_W-1:0]      tier_q, tier_d;
  logic [SUM_W-1:0]       tot_q, tot_d;

  // Output register
  logic                   out_valid_q;
  logic [TIER_W-1:0]      out_tier_q;
  logic [OUT_W-1:0]       out_avg_q;
  logic [SUM_W-1:0]       out_tot_q;
  logic [OUT_W-1:0]       out_min_q;
  logic [OUT_W-1:0]       out_max_q;
  logic [FLAG_W-1:0]      out_flag_q;

  state_e state_q, state_d;

  // Control
  logic                   take_sample;
  logic                   take_close;
  logic                   close_empty;
  logic                   div_start;
  logic                   add_run;
  logic                   add_last;
  logic                   fin_go;
  logic [TIER_W-1:0]      close_tier;
  logic [SAMPLE_BITS-1:0] smp;
  logic [NUM_TIERS-1:0]   dst_mask;

  logic [SUM_W-1:0]       quotient;
  div_status_t            div_status;

  logic [OUT_W-1:0]       avg_sat;
  logic [SUM_W-1:0]       min_ext;
  logic [SUM_W-1:0]       max_ext;
  logic [FLAG_W-1:0]      flag;

  assign smp        = SAMPLE_BITS'(SUM_W'(sample_value_i));
  assign close_tier = func_i[TIER_W-1:0] - TIER_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end else if (take_sample) begin
          state_d = ST_ADD;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = (dst_mask != '0) ? ST_ADD : ST_IDLE;
        end
      end
      ST_ADD: begin
        if (add_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    take_sample = 1'b0;
    take_close  = 1'b0;
    add_run     = 1'b0;
    fin_go      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        case (func_e'(func_i))
          FN_SAMPLE:       take_sample = in_valid_i;
          FN_CLOSE_MINUTE,
          FN_CLOSE_FIVE,
          FN_CLOSE_HOUR,
          FN_CLOSE_DAY:    take_close  = in_valid_i;
          default:         take_close  = 1'b0;
        endcase
      end
      ST_ADD:  add_run = 1'b1;
      ST_FIN:  fin_go  = ~out_valid_q | out_ready_i;
      default: add_run = 1'b0;
    endcase
  end

  assign close_empty = take_close & (cnt_q[close_tier] == '0);
  assign div_start   = take_close & (cnt_q[close_tier] != '0);
  assign add_last    = add_run & (step_q == STEP_W'(SUM_W - 1));

  // Minute average feeds the hour tier, hour average feeds the day tier
  always_comb begin
    case (tier_e'(tier_q))
      TIER_MINUTE: dst_mask = NUM_TIERS'(1) << TIER_HOUR;
      TIER_HOUR:   dst_mask = NUM_TIERS'(1) << TIER_DAY;
      default:     dst_mask = '0;
    endcase
  end

  tsa_serial_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[close_tier]),
    .divisor_i  (cnt_q[close_tier]),
    .upper_i    (upper_q),
    .lower_i    (lower_q),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  // Result fields, saturated to the output width
  assign avg_sat = (quotient[SUM_W-1:OUT_W] != '0) ? OUT_MAX : quotient[OUT_W-1:0];
  assign min_ext = SUM_W'(min_q[tier_q]);
  assign max_ext = SUM_W'(max_q[tier_q]);

  always_comb begin
    flag = div_status.out_of_range ? FLAG_OOR : FLAG_NORMAL;
    if ((tier_q == TIER_HOUR) || (tier_q == TIER_DAY)) begin
      case (mode_e'(mode_q))
        MODE_NORMAL: flag = div_status.out_of_range ? FLAG_OOR : FLAG_NORMAL;
        MODE_ZERO:   flag = FLAG_ZERO;
        MODE_SPAN:   flag = FLAG_SPAN;
        default:     flag = FLAG_NORMAL;
      endcase
    end
  end

  // Datapath next values
  always_comb begin
    logic bit_in;
    logic s_bit;
    logic c_bit;
    logic m_bit;
    logic x_bit;

    sums_d   = sums_q;
    cnt_d    = cnt_q;
    min_d    = min_q;
    max_d    = max_q;
    mode_d   = mode_q;
    add_sh_d = add_sh_q;
    v_d      = v_q;
    mask_d   = mask_q;
    carry_d  = carry_q;
    lt_d     = lt_q;
    gt_d     = gt_q;
    cmp_en_d = cmp_en_q;
    step_d   = step_q;
    tier_d   = tier_q;
    tot_d    = tot_q;
    bit_in   = add_sh_q[0];
    s_bit    = 1'b0;
    c_bit    = 1'b0;
    m_bit    = 1'b0;
    x_bit    = 1'b0;

    // Load a sample for the minute and five-minute sums and all extremes
    if (take_sample) begin
      v_d      = smp;
      add_sh_d = SUM_W'(smp);
      mask_d   = (NUM_TIERS'(1) << TIER_MINUTE) | (NUM_TIERS'(1) << TIER_FIVE);
      cmp_en_d = 1'b1;
      carry_d  = '0;
      lt_d     = '0;
      gt_d     = '0;
      step_d   = '0;
      mode_d   = run_mode_i;
    end

    // Capture the tier being closed; drop an empty tier at once
    if (take_close) begin
      tier_d = close_tier;
      tot_d  = sums_q[close_tier];
      if (close_empty) begin
        sums_d[close_tier] = '0;
        cnt_d[close_tier]  = '0;
        min_d[close_tier]  = '1;
        max_d[close_tier]  = '0;
      end
    end

    // One bit per cycle: rotate sums through the serial adder, extremes through comparators
    if (add_run) begin
      add_sh_d = add_sh_q >> 1;
      step_d   = step_q + STEP_W'(1);
      for (int t = 0; t < NUM_TIERS; t++) begin
        if (mask_q[t]) begin
          s_bit      = sums_q[t][0] ^ bit_in ^ carry_q[t];
          c_bit      = (sums_q[t][0] & bit_in) | (sums_q[t][0] & carry_q[t]) |
                       (bit_in & carry_q[t]);
          sums_d[t]  = {s_bit, sums_q[t][SUM_W-1:1]};
          carry_d[t] = c_bit;
          if (add_last) begin
            if (c_bit) begin
              sums_d[t] = '1;
            end
            if (cnt_q[t] != '1) begin
              cnt_d[t] = cnt_q[t] + COUNT_BITS'(1);
            end
          end
        end
        if (cmp_en_q && ({1'b0, step_q} < (STEP_W + 1)'(SAMPLE_BITS))) begin
          m_bit    = min_q[t][0];
          x_bit    = max_q[t][0];
          min_d[t] = {m_bit, min_q[t][SAMPLE_BITS-1:1]};
          max_d[t] = {x_bit, max_q[t][SAMPLE_BITS-1:1]};
          if (bit_in != m_bit) begin
            lt_d[t] = ~bit_in;
          end
          if (bit_in != x_bit) begin
            gt_d[t] = bit_in;
          end
        end
        if (add_last && cmp_en_q) begin
          if (lt_d[t]) begin
            min_d[t] = v_q;
          end
          if (gt_d[t]) begin
            max_d[t] = v_q;
          end
        end
      end
    end

    // Clear the closed tier and, for a minute or hour tier, queue its average for the next tier
    if (fin_go) begin
      sums_d[tier_q] = '0;
      cnt_d[tier_q]  = '0;
      min_d[tier_q]  = '1;
      max_d[tier_q]  = '0;
      add_sh_d       = quotient;
      mask_d         = dst_mask;
      cmp_en_d       = 1'b0;
      carry_d        = '0;
      step_d         = '0;
    end
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      upper_q  <= OUT_MAX;
      lower_q  <= '0;
      mode_q   <= '0;
      mask_q   <= '0;
      cmp_en_q <= 1'b0;
      step_q   <= '0;
      for (int t = 0; t < NUM_TIERS; t++) begin
        sums_q[t] <= '0;
        cnt_q[t]  <= '0;
        min_q[t]  <= '1;
        max_q[t]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      mask_q   <= mask_d;
      cmp_en_q <= cmp_en_d;
      step_q   <= step_d;
      sums_q   <= sums_d;
      cnt_q    <= cnt_d;
      min_q    <= min_d;
      max_q    <= max_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_UPPER: upper_q <= cfg_wdata_i;
          REG_LOWER: lower_q <= cfg_wdata_i;
          default:   upper_q <= upper_q;
        endcase
      end
    end
  end

  // Serial working registers
  always_ff @(posedge clk_i) begin
    add_sh_q <= add_sh_d;
    v_q      <= v_d;
    carry_q  <= carry_d;
    lt_q     <= lt_d;
    gt_q     <= gt_d;
    tier_q   <= tier_d;
    tot_q    <= tot_d;
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_tier_q <= tier_q;
      out_avg_q  <= avg_sat;
      out_tot_q  <= tot_q;
      out_min_q  <= (min_ext[SUM_W-1:OUT_W] != '0) ? OUT_MAX : min_ext[OUT_W-1:0];
      out_max_q  <= (max_ext[SUM_W-1:OUT_W] != '0) ? OUT_MAX : max_ext[OUT_W-1:0];
      out_flag_q <= flag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tier_o         = out_tier_q;
  assign average_o      = out_avg_q;
  assign total_o        = out_tot_q;
  assign minimum_o      = out_min_q;
  assign maximum_o      = out_max_q;
  assign quality_flag_o = out_flag_q;

endmodule

// ===== design/tsa_checker.sv =====
module tsa_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic [tsa_pkg::FUNC_W-1:0]      func_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [tsa_pkg::TIER_W-1:0]      tier_o,
  input  logic [tsa_pkg::OUT_W-1:0]       average_o,
  input  logic [tsa_pkg::SUM_W-1:0]       total_o,
  input  logic [tsa_pkg::OUT_W-1:0]       minimum_o,
  input  logic [tsa_pkg::OUT_W-1:0]       maximum_o,
  input  logic [tsa_pkg::FLAG_W-1:0]      quality_flag_o
);
  import tsa_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_o) && $stable(average_o) &&
      $stable(tier_o) && $stable(quality_flag_o))
    else $error("stalled result changed");

  // Sample tiers never carry a mode code
  a_fast_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tier_o == TIER_MINUTE || tier_o == TIER_FIVE) |-> !quality_flag_o[1])
    else $error("mode flag on minute or five-minute tier");

  // Sample tier average lies between its extremes
  a_avg_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tier_o == TIER_MINUTE || tier_o == TIER_FIVE) |->
      minimum_o <= average_o && average_o <= maximum_o)
    else $error("average outside min/max");

  // A zero sum averages to zero
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_o == '0 |-> average_o == '0)
    else $error("nonzero average from zero sum");

  // A sample item never produces a result right away
  a_sample_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FN_SAMPLE |=> !$rose(out_valid_o))
    else $error("result raised by a sample item");

endmodule

bind tiered_sample_averager tsa_checker u_tsa_checker (.*);
